/* design/mpsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-page shelf packer package
// Request and response payload types, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package mpsp_pkg;

   // Default sizes of the page store.
   localparam int DEF_PAGE_EXTENT = 2048;
   localparam int DEF_PAD         = 1;
   localparam int DEF_MAX_PAGES   = 8;

   // Response status codes.
   localparam logic [1:0] STATUS_PLACED    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
   localparam logic [1:0] STATUS_NO_PAGE   = 2'd3;

   // One rectangle to place.
   typedef struct packed {
      logic [11:0] rect_width;
      logic [11:0] rect_height;
      logic        is_color;
   } req_type;

   // Placement result for one rectangle.
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  page_index;
      logic [10:0] x_pos;
      logic [10:0] y_pos;
      logic        opened_page;
   } rsp_type;

endpackage
`default_nettype wire

/* design/multi_page_shelf_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-page shelf packer
// Places padded rectangles into square pages with shelf packing.
// ----------------------------------------------------------------------------
// Usage:
// A request carries a rectangle size and its color class. It is accepted when
// req_valid is high and req_stall is low. Each request yields exactly one
// response on the rsp_ channel, taken when rsp_valid is high and rsp_stall is
// low. The block handles one request at a time and holds req_stall high while
// it works. Empty and oversized rectangles go from idle straight to the done
// state. Otherwise the shared fit comparator walks the open pages one per cycle
// from a page memory with a registered read; a fitting request then passes
// through the place state, and every request passes through the done state
// before its response is loaded into the output register. A new request may
// be accepted while the previous response still waits in the output register.
// When the receiver stalls, the response holds; a finished request then waits
// until the output register is free. Reset empties all pages at once: pages
// open in index order, so a count of open pages marks which memory entries are valid.
// ----------------------------------------------------------------------------
module multi_page_shelf_packer #(
   parameter int PAGE_EXTENT = mpsp_pkg::DEF_PAGE_EXTENT,
   parameter int PAD         = mpsp_pkg::DEF_PAD,
   parameter int MAX_PAGES   = mpsp_pkg::DEF_MAX_PAGES
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  mpsp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output mpsp_pkg::rsp_type  rsp_data
);
   import mpsp_pkg::*;

   // Widths derived from the page geometry and the page count.
   localparam int EXT_W = $clog2(PAGE_EXTENT + 1);
   localparam int SUM_W = ((EXT_W > 13) ? EXT_W : 13) + 2;
   localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_W = $clog2(MAX_PAGES + 1);
   localparam logic [SUM_W-1:0] EXT_SUM  = SUM_W'(PAGE_EXTENT);
   localparam logic [CNT_W-1:0] PAGE_CNT = CNT_W'(MAX_PAGES);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_PLACE = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   // Shelf state of one page.
   typedef struct packed {
      logic             cls;
      logic [EXT_W-1:0] rx;
      logic [EXT_W-1:0] ry;
      logic [EXT_W-1:0] rh;
   } page_type;

   logic [1:0]       state_ff, state_in;
   logic [12:0]      pw_ff, pw_in;
   logic [12:0]      ph_ff, ph_in;
   logic             cls_ff, cls_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   page_type         rd_data_ff;
   page_type         tgt_ff, tgt_in;
   logic [IDX_W-1:0] tgt_idx_ff, tgt_idx_in;
   logic             opened_ff, opened_in;
   logic [CNT_W-1:0] open_count_ff, open_count_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   page_type         page_mem [MAX_PAGES];
   logic             rd_issue;
   logic             mem_we;
   page_type         wr_entry;

   logic             accept;
   logic             out_free;
   logic [12:0]      req_pw;
   logic [12:0]      req_ph;
   logic             same_row;
   logic             next_row;
   logic             hit;
   logic             wrap;
   logic [EXT_W-1:0] place_x;
   logic [EXT_W-1:0] place_y;
   logic [EXT_W-1:0] place_h;
   logic [EXT_W-1:0] next_x;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Padded size of the incoming rectangle.
   assign req_pw = 13'(req_data.rect_width) + 13'(PAD);
   assign req_ph = 13'(req_data.rect_height) + 13'(PAD);

   // Shared fit comparator, applied to the page read in the previous cycle.
   assign same_row = (SUM_W'(rd_data_ff.rx) + SUM_W'(pw_ff) <= EXT_SUM) &&
                     (SUM_W'(rd_data_ff.ry) + SUM_W'(ph_ff) <= EXT_SUM);
   assign next_row = (SUM_W'(pw_ff) <= EXT_SUM) &&
                     (SUM_W'(rd_data_ff.ry) + SUM_W'(rd_data_ff.rh) + SUM_W'(ph_ff)
                      <= EXT_SUM);
   assign hit      = rd_valid_ff && (rd_data_ff.cls == cls_ff) && (same_row || next_row);

   // Placement on the chosen page; a full row is closed first.
   assign wrap    = (SUM_W'(tgt_ff.rx) + SUM_W'(pw_ff)) > EXT_SUM;
   assign place_x = wrap ? '0 : tgt_ff.rx;
   assign place_y = wrap ? EXT_W'(SUM_W'(tgt_ff.ry) + SUM_W'(tgt_ff.rh)) : tgt_ff.ry;
   assign place_h = (wrap || (SUM_W'(tgt_ff.rh) < SUM_W'(ph_ff))) ? EXT_W'(ph_ff)
                                                                     : tgt_ff.rh;
   assign next_x  = EXT_W'(SUM_W'(place_x) + SUM_W'(pw_ff));

   assign rd_issue = (state_ff == S_SCAN) && (scan_idx_ff < open_count_ff);
   assign mem_we   = (state_ff == S_PLACE);
   always_comb begin
      wr_entry.cls = cls_ff;
      wr_entry.rx  = next_x;
      wr_entry.ry  = place_y;
      wr_entry.rh  = place_h;
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      pw_in         = pw_ff;
      ph_in         = ph_ff;
      cls_in        = cls_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      tgt_in        = tgt_ff;
      tgt_idx_in    = tgt_idx_ff;
      opened_in     = opened_ff;
      open_count_in = open_count_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pw_in       = req_pw;
               ph_in       = req_ph;
               cls_in      = req_data.is_color;
               scan_idx_in = '0;
               res_in      = '0;
               priority if (req_data.rect_width == 12'd0 ||
                            req_data.rect_height == 12'd0) begin
                  res_in.status = STATUS_EMPTY;
                  state_in      = S_DONE;
               end else if (SUM_W'(req_pw) > EXT_SUM || SUM_W'(req_ph) > EXT_SUM) begin
                  res_in.status = STATUS_TOO_LARGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Keep one page read in flight while the previous one is tested.
            if (rd_issue) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            priority if (hit) begin
               rd_valid_in = 1'b0;
               tgt_in      = rd_data_ff;
               tgt_idx_in  = rd_idx_ff;
               opened_in   = 1'b0;
               state_in    = S_PLACE;
            end else if (!rd_valid_ff && !rd_issue) begin
               // No open page fits: open the next one or give up.
               if (open_count_ff < PAGE_CNT) begin
                  tgt_in     = '0;
                  tgt_idx_in = open_count_ff[IDX_W-1:0];
                  opened_in  = 1'b1;
                  state_in   = S_PLACE;
               end else begin
                  res_in.status = STATUS_NO_PAGE;
                  state_in      = S_DONE;
               end
            end
         end
         S_PLACE: begin
            if (opened_ff) begin
               open_count_in = open_count_ff + 1'b1;
            end
            res_in.status      = STATUS_PLACED;
            res_in.page_index  = 3'(tgt_idx_ff);
            res_in.x_pos       = 11'(place_x);
            res_in.y_pos       = 11'(place_y);
            res_in.opened_page = opened_ff;
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Page memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[tgt_idx_ff] <= wr_entry;
      end
      if (rd_issue) begin
         rd_data_ff <= page_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_valid_ff   <= 1'b0;
         open_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         open_count_ff <= open_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pw_ff       <= pw_in;
      ph_ff       <= ph_in;
      cls_ff      <= cls_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      tgt_ff      <= tgt_in;
      tgt_idx_ff  <= tgt_idx_in;
      opened_ff   <= opened_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // The open page count never passes the page store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      open_count_ff <= PAGE_CNT)
      else $error("open page count exceeds page store");

   // A page under test is always one that is already open.
   a_read_open: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (CNT_W'(rd_idx_ff) < open_count_ff))
      else $error("tested page is not open");

   // Placement only follows a page scan.
   a_place_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |-> ($past(state_ff) == S_SCAN))
      else $error("placement without scan");

   // The page count grows only in the cycle after opening a page.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (open_count_ff != $past(open_count_ff)) |->
         ($past(state_ff) == S_PLACE && $past(opened_ff)))
      else $error("unexpected change of open page count");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");
`endif

endmodule
`default_nettype wire
